@@ rtl/core/bstp_pkg.sv @@
// shared types and constants for the bottleneck spanning tree unit
package bstp_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned DIST_W  = 33;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]  dist_t;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_INIT  = 7'b0000010,
        ST_IMUL  = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_UPD   = 7'b0010000,
        ST_UMUL  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

endpackage

@@ rtl/core/bottleneck_spanning_tree_points_unit.sv @@
// top level of the bottleneck spanning tree unit
//
// points enter on the s_ channel one transaction per cycle while loading;
// s_axis_tdata holds x (bits 15:0) and y (bits 31:16), s_axis_tlast marks
// the final point of a set. that final point is stored, then prim's method
// runs over the stored points: one shared squaring unit and one compare,
// used once per point per step, with best distances held in a memory.
// the result (largest tree edge, 33 bits in a 40-bit tdata) is offered on
// the m_ channel as a single transaction.
// compute after the last point, for n points: a seeding sweep squares each
// point's distance to point 0 and drains the squaring pipeline, then each of
// the n-1 tree steps scans the best distances, reads the new pivot and sweeps
// the points again to update them (a single point goes straight to the
// result); the memory read port and the single squaring unit set the pace.
// s_axis_tready is low from the last point until the result is taken; a
// stalled receiver simply holds the result. points beyond MAX_POINTS are
// dropped. reset (aresetn low, synchronous) empties the set and clears the
// pending result; point memories need no clearing.
module bottleneck_spanning_tree_points_unit #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // x_coord[15:0], y_coord[31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // max_sq_distance[32:0], zero fill
);
    import bstp_pkg::*;

    localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

    // point and best-distance memories
    coord_t xs_mem [MAX_POINTS];
    coord_t ys_mem [MAX_POINTS];
    dist_t  bd_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] in_tree_reg, in_tree_next;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;     // scan / update index
    logic [IDX_W-1:0] pick_reg, pick_next;   // newest tree member
    logic             found_reg, found_next;
    dist_t            low_reg, low_next;
    logic [IDX_W-1:0] cand_reg, cand_next;
    dist_t            max_reg, max_next;
    logic [CNT_W-1:0] steps_reg, steps_next;

    // registered reads
    coord_t px_reg, py_reg, qx_reg, qy_reg;
    dist_t  bd_reg;
    logic   rd_ok_reg;                        // read data valid for idx of previous cycle
    logic   rd_seed_reg;                      // that read belongs to the seeding sweep
    logic [IDX_W-1:0] rd_idx_reg;

    // squaring unit pipeline
    logic [COORD_W-1:0] dx, dy;
    logic [2*COORD_W-1:0] sqx_reg, sqy_reg;
    dist_t  dist_sum;
    dist_t  sum_reg;

    logic s_acc, m_acc, store_ok;
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign m_acc    = m_axis_tvalid && m_axis_tready;
    assign store_ok = count_reg < CNT_W'(MAX_POINTS);

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {{(40-DIST_W){1'b0}}, max_reg};

    assign dx = (px_reg > qx_reg) ? px_reg - qx_reg : qx_reg - px_reg;
    assign dy = (py_reg > qy_reg) ? py_reg - qy_reg : qy_reg - py_reg;
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    logic [IDX_W-1:0] last_idx;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // memory access: write on load, read at idx_reg
    logic bd_we;
    logic [IDX_W-1:0] bd_wa;
    dist_t bd_wd;

    always_ff @(posedge aclk) begin
        if (s_acc && store_ok) begin
            xs_mem[IDX_W'(count_reg)] <= s_axis_tdata[15:0];
            ys_mem[IDX_W'(count_reg)] <= s_axis_tdata[31:16];
        end
        qx_reg     <= xs_mem[idx_reg];
        qy_reg     <= ys_mem[idx_reg];
        bd_reg     <= bd_mem[idx_reg];
        rd_idx_reg <= idx_reg;
        if (bd_we) begin
            bd_mem[bd_wa] <= bd_wd;
        end
        sqx_reg <= dx * dx;
        sqy_reg <= dy * dy;
        sum_reg <= dist_sum;
    end

    // the pivot point is latched from a read the cycle after its index is set
    logic pivot_load_reg;
    always_ff @(posedge aclk) begin
        if (pivot_load_reg) begin
            px_reg <= qx_reg;
            py_reg <= qy_reg;
        end
    end

    // pipeline of update candidates: index and old best distance, two stages
    logic [1:0]       pv_reg;
    logic [IDX_W-1:0] pi0_reg, pi1_reg;
    dist_t            pb0_reg, pb1_reg;
    logic             pseed0_reg, pseed1_reg;
    logic             issue, issue_seed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else begin
            pv_reg <= {pv_reg[0], rd_ok_reg};
        end
        pi0_reg    <= rd_idx_reg;
        pb0_reg    <= bd_reg;
        pseed0_reg <= rd_seed_reg;
        pi1_reg    <= pi0_reg;
        pb1_reg    <= pb0_reg;
        pseed1_reg <= pseed0_reg;
    end

    // sum_reg aligns with stage 1 (read -> square -> sum)
    always_comb begin
        bd_we = 1'b0;
        bd_wa = pi1_reg;
        bd_wd = sum_reg;
        if (pv_reg[1] && !in_tree_reg[pi1_reg]) begin
            if (pseed1_reg || sum_reg < pb1_reg) begin
                bd_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ok_reg      <= 1'b0;
            rd_seed_reg    <= 1'b0;
            pivot_load_reg <= 1'b0;
        end else begin
            rd_ok_reg      <= issue;
            rd_seed_reg    <= issue_seed;
            pivot_load_reg <= (state_reg == ST_INIT) || (state_reg == ST_UMUL);
        end
    end

    logic scan_v;   // scan read issued
    logic scan_v_reg;
    logic [IDX_W-1:0] scan_i_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pick_next    = pick_reg;
        found_next   = found_reg;
        low_next     = low_reg;
        cand_next    = cand_reg;
        max_next     = max_reg;
        steps_next   = steps_reg;
        in_tree_next = in_tree_reg;
        issue        = 1'b0;
        issue_seed   = 1'b0;
        scan_v       = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (store_ok) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_axis_tlast) begin
                        max_next = '0;
                        idx_next = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // point 0 read is under way; it then passes through qx/qy_reg into the pivot
                if (count_reg < CNT_W'(2)) begin
                    state_next = ST_OUT;
                end else begin
                    in_tree_next[0] = 1'b1;
                    idx_next = IDX_W'(1);
                    state_next = ST_IMUL;
                end
            end
            ST_IMUL: begin
                // seed best distances from point 0
                issue      = 1'b1;
                issue_seed = 1'b1;
                if (idx_reg == last_idx) begin
                    idx_next   = IDX_W'(1);
                    found_next = 1'b0;
                    steps_next = CNT_W'(1);
                    state_next = ST_UPD;   // drain, then scan
                    pick_next  = '0;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SCAN: begin
                scan_v = 1'b1;
                if (scan_v_reg && !in_tree_reg[scan_i_reg] &&
                    (!found_reg || bd_reg < low_reg)) begin
                    found_next = 1'b1;
                    low_next   = bd_reg;
                    cand_next  = scan_i_reg;
                end
                if (idx_reg != last_idx) begin
                    idx_next = idx_reg + IDX_W'(1);
                end else if (scan_v_reg && scan_i_reg == last_idx) begin
                    // all candidates seen; commit pick
                    if (!found_next) begin
                        state_next = ST_OUT;
                    end else begin
                        in_tree_next[cand_next] = 1'b1;
                        pick_next = cand_next;
                        if (low_next > max_reg) begin
                            max_next = low_next;
                        end
                        idx_next   = cand_next;
                        state_next = ST_UMUL;
                    end
                end
            end
            ST_UMUL: begin
                // pivot read issued this cycle; start update sweep
                idx_next = IDX_W'(1);
                state_next = ST_UPD;
                steps_next = steps_reg + CNT_W'(1);
                found_next = 1'b0;
            end
            ST_UPD: begin
                // first cycle after seeding arrives here with pivot ready
                if (pivot_load_reg || pv_reg != 2'b00 || rd_ok_reg || idx_reg != '0) begin
                    if (idx_reg != '0 && pick_reg != '0 || idx_reg != '0 && steps_reg != CNT_W'(1)) begin
                        issue = 1'b1;
                    end
                end
                if (issue) begin
                    idx_next = (idx_reg == last_idx) ? '0 : idx_reg + IDX_W'(1);
                end else if (!rd_ok_reg && pv_reg == 2'b00 && !pivot_load_reg) begin
                    if (steps_reg >= count_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        idx_next   = IDX_W'(1);
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    count_next   = '0;
                    in_tree_next = '0;
                    state_next   = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            in_tree_reg <= '0;
            max_reg     <= '0;
            scan_v_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            in_tree_reg <= in_tree_next;
            max_reg     <= max_next;
            scan_v_reg  <= scan_v && state_next == ST_SCAN;
        end
        idx_reg    <= idx_next;
        pick_reg   <= pick_next;
        found_reg  <= found_next;
        low_reg    <= low_next;
        cand_reg   <= cand_next;
        steps_reg  <= steps_next;
        scan_i_reg <= idx_reg;
    end

    // the input side never takes a point while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");
    // the point count never exceeds the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count overflow");
    // the tree is empty whenever loading restarts
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc |=> (in_tree_reg == '0))
        else $error("tree marks not cleared");

endmodule
